/* sv/fogd_pkg.sv */
// Shared types and constants of the fourth-order grid derivative unit
package fogd_pkg;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int LEN_CFG_WIDTH   = 11;
    localparam int SCALE_WIDTH     = 32;
    localparam int OUT_WIDTH       = 40;
    localparam int FRAC_SHIFT      = 16;
    localparam int ROUND_HALF      = 32768;
    localparam int QUEUE_DEPTH     = 4;
    localparam int OUT_DEPTH       = 4;
    localparam int TAPS            = 5;
    localparam int SLOTS           = 4;
    localparam int MIN_LEN         = 4;

    localparam logic [LEN_CFG_WIDTH-1:0] LEN_RESET   = 11'd1024;
    localparam logic [SCALE_WIDTH-1:0]   SCALE_RESET = 32'h0001_0000;
    localparam logic [40:0]              SAT_POS     = 41'h07F_FFFF_FFFF;
    localparam logic [40:0]              SAT_NEG_MAG = 41'h080_0000_0000;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_SECOND_ORDER  = 3'd0,
        REG_ALONG_COLUMNS = 3'd1,
        REG_ROW_LENGTH    = 3'd2,
        REG_ROW_COUNT     = 3'd3,
        REG_STEP_SCALE    = 3'd4
    } fogd_reg_t;

    typedef struct packed {
        logic three;
        logic frame;
    } fogd_ctl_t;

    typedef struct packed {
        logic run;
        logic frame;
    } fogd_flags_t;

endpackage

/* sv/fourth_order_grid_derivative_unit.sv */
// Top level of the fourth-order grid derivative unit
//
//  channel | signals                                          | item
//  --------+--------------------------------------------------+---------------------------
//  in      | in_valid, in_stall, sample_re, sample_im         | one grid sample
//  out     | out_valid, out_stall, deriv_re, deriv_im,        | one derivative point
//          | run_end, frame_end                               |
//  cfg     | cfg_write, cfg_index, cfg_data                   | one register write
//
//  One sample per cycle while in_stall is low; the back end's single stencil/multiplier
//  path issues one result per cycle while a job is queued and the output FIFO has room, so
//  a sample that yields three results (row end along x, every sample of the last row along
//  y) holds the input once the 4-entry queue fills.
//  Reset clears positions, window and queues; the row stores need no clearing pass.
//  Either side may stall at any time; a full output FIFO stops issue, then the input.
module fourth_order_grid_derivative_unit #(
    parameter int MAX_ROW_LENGTH = 1024,
    parameter int MAX_ROW_COUNT  = 1024,
    parameter int SAMPLE_WIDTH   = 24
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]            sample_re,
    input  logic signed [SAMPLE_WIDTH-1:0]            sample_im,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic signed [fogd_pkg::OUT_WIDTH-1:0]     deriv_re,
    output logic signed [fogd_pkg::OUT_WIDTH-1:0]     deriv_im,
    output logic                                      run_end,
    output logic                                      frame_end,
    input  logic                                      cfg_write,
    input  logic [fogd_pkg::CFG_INDEX_WIDTH-1:0]      cfg_index,
    input  logic [fogd_pkg::CFG_DATA_WIDTH-1:0]       cfg_data
);

    import fogd_pkg::*;

    localparam int EW  = TAPS*2*SAMPLE_WIDTH + $bits(fogd_ctl_t);
    localparam int QCW = $clog2(QUEUE_DEPTH+1);

    logic                     second_order_reg;
    logic                     along_columns_reg;
    logic [LEN_CFG_WIDTH-1:0] row_length_reg;
    logic [LEN_CFG_WIDTH-1:0] row_count_reg;
    logic [SCALE_WIDTH-1:0]   step_scale_reg;
    logic                     restart;

    logic                     q_push;
    logic [EW-1:0]            q_push_data;
    logic                     q_pop;
    logic [EW-1:0]            q_head;
    logic [QCW-1:0]           q_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_order_reg  <= 1'b0;
            along_columns_reg <= 1'b0;
            row_length_reg    <= LEN_RESET;
            row_count_reg     <= LEN_RESET;
            step_scale_reg    <= SCALE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SECOND_ORDER:  second_order_reg  <= cfg_data[0];
                REG_ALONG_COLUMNS: along_columns_reg <= cfg_data[0];
                REG_ROW_LENGTH:    row_length_reg    <= cfg_data[LEN_CFG_WIDTH-1:0];
                REG_ROW_COUNT:     row_count_reg     <= cfg_data[LEN_CFG_WIDTH-1:0];
                REG_STEP_SCALE:    step_scale_reg    <= cfg_data[SCALE_WIDTH-1:0];
                default:           ;
            endcase
        end
    end

    // geometry writes restart the frame
    always_comb
    begin
        restart = cfg_write &&
                  (cfg_index inside {REG_ALONG_COLUMNS, REG_ROW_LENGTH, REG_ROW_COUNT});
    end

    fogd_front #(
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
        .MAX_ROW_COUNT  (MAX_ROW_COUNT),
        .SAMPLE_WIDTH   (SAMPLE_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample_re     (sample_re),
        .sample_im     (sample_im),
        .along_columns (along_columns_reg),
        .row_length    (row_length_reg),
        .row_count     (row_count_reg),
        .restart       (restart),
        .q_count       (q_count),
        .push          (q_push),
        .push_data     (q_push_data)
    );

    fogd_fifo #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head      (q_head),
        .count     (q_count)
    );

    fogd_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .q_count      (q_count),
        .pop          (q_pop),
        .second_order (second_order_reg),
        .step_scale   (step_scale_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .deriv_re     (deriv_re),
        .deriv_im     (deriv_im),
        .run_end      (run_end),
        .frame_end    (frame_end)
    );

endmodule

/* sv/fogd_ram.sv */
// Generic single-write, single-read RAM with registered read data
module fogd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

/* sv/fogd_fifo.sv */
// Small register FIFO with occupancy count
module fogd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           head,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTRW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTRW-1:0]  wr_ptr_reg;
    logic [PTRW-1:0]  rd_ptr_reg;
    logic [CNTW-1:0]  count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTRW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTRW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNTW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNTW'(1);
            end
        end
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

/* sv/fogd_front.sv */
// Front end: accepts samples, tracks raster position, gathers stencil taps
module fogd_front #(
    parameter int MAX_ROW_LENGTH = 1024,
    parameter int MAX_ROW_COUNT  = 1024,
    parameter int SAMPLE_WIDTH   = 24
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         in_valid,
    output logic                                         in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]               sample_re,
    input  logic signed [SAMPLE_WIDTH-1:0]               sample_im,
    input  logic                                         along_columns,
    input  logic [fogd_pkg::LEN_CFG_WIDTH-1:0]           row_length,
    input  logic [fogd_pkg::LEN_CFG_WIDTH-1:0]           row_count,
    input  logic                                         restart,
    input  logic [$clog2(fogd_pkg::QUEUE_DEPTH+1)-1:0]   q_count,
    output logic                                         push,
    output logic [fogd_pkg::TAPS*2*SAMPLE_WIDTH+$bits(fogd_pkg::fogd_ctl_t)-1:0] push_data
);

    import fogd_pkg::*;

    localparam int CW = $clog2(MAX_ROW_LENGTH);
    localparam int RW = $clog2(MAX_ROW_COUNT);
    localparam int LW = $clog2(MAX_ROW_LENGTH+1);
    localparam int NW = $clog2(MAX_ROW_COUNT+1);
    localparam int PW = 2*SAMPLE_WIDTH;

    logic [LW-1:0] len;
    logic [NW-1:0] cnt;
    logic          accept;
    logic          last_col;
    logic          last_row;
    logic [PW-1:0] v;

    logic [CW-1:0] c_reg;
    logic [RW-1:0] r_reg;
    logic [PW-1:0] win_reg [SLOTS];

    logic          f1_valid_reg;
    logic [PW-1:0] f1_v_reg;
    logic [PW-1:0] f1_win_reg [SLOTS];
    logic          f1_cols_reg;
    logic [1:0]    f1_slot_reg;
    logic [3:0]    f1_gate_reg;
    logic          f1_emit_reg;
    logic          f1_three_reg;
    logic          f1_frame_reg;

    logic [PW-1:0] rd_data [SLOTS];
    logic [PW-1:0] taps [TAPS];
    fogd_ctl_t     ctl;

    always_comb
    begin
        if (row_length < LEN_CFG_WIDTH'(MIN_LEN))
        begin
            len = LW'(MIN_LEN);
        end
        else if (32'(row_length) > MAX_ROW_LENGTH)
        begin
            len = LW'(MAX_ROW_LENGTH);
        end
        else
        begin
            len = LW'(row_length);
        end
        if (row_count < LEN_CFG_WIDTH'(MIN_LEN))
        begin
            cnt = NW'(MIN_LEN);
        end
        else if (32'(row_count) > MAX_ROW_COUNT)
        begin
            cnt = NW'(MAX_ROW_COUNT);
        end
        else
        begin
            cnt = NW'(row_count);
        end
    end

    assign in_stall = (32'(q_count) + 32'(f1_valid_reg)) >= QUEUE_DEPTH;
    assign accept   = in_valid && !in_stall;
    assign last_col = 32'(c_reg) == (32'(len) - 32'd1);
    assign last_row = 32'(r_reg) == (32'(cnt) - 32'd1);
    assign v        = {sample_re, sample_im};

    // raster position and row window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg <= '0;
            r_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (restart)
        begin
            c_reg <= '0;
            r_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            if (last_col)
            begin
                c_reg <= '0;
                r_reg <= last_row ? '0 : r_reg + RW'(1);
                for (int i = 0; i < SLOTS; i++)
                begin
                    win_reg[i] <= '0;
                end
            end
            else
            begin
                c_reg      <= c_reg + CW'(1);
                win_reg[0] <= v;
                for (int i = 1; i < SLOTS; i++)
                begin
                    win_reg[i] <= win_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_v_reg    <= v;
            f1_win_reg  <= win_reg;
            f1_cols_reg <= along_columns;
            f1_slot_reg <= r_reg[1:0];
            for (int k = 1; k <= SLOTS; k++)
            begin
                f1_gate_reg[k-1] <= 32'(r_reg) >= k;
            end
            f1_emit_reg  <= along_columns ? (r_reg >= RW'(2)) : (c_reg >= CW'(2));
            f1_three_reg <= along_columns ? last_row : last_col;
            f1_frame_reg <= last_col && last_row;
        end
    end

    // one row store per slot, slot = row mod 4
    for (genvar s = 0; s < SLOTS; s++)
    begin : g_row
        fogd_ram #(
            .WIDTH(PW),
            .DEPTH(MAX_ROW_LENGTH)
        ) u_ram (
            .clk   (clk),
            .we    (accept && along_columns && (r_reg[1:0] == 2'(s))),
            .waddr (c_reg),
            .wdata (v),
            .re    (accept),
            .raddr (c_reg),
            .rdata (rd_data[s])
        );
    end

    always_comb
    begin
        logic [1:0] src;
        src = '0;
        taps[TAPS-1] = f1_v_reg;
        for (int k = 1; k <= SLOTS; k++)
        begin
            src = f1_slot_reg - 2'(k);
            if (f1_cols_reg)
            begin
                taps[TAPS-1-k] = f1_gate_reg[k-1] ? rd_data[src] : '0;
            end
            else
            begin
                taps[TAPS-1-k] = f1_win_reg[k-1];
            end
        end
        ctl.three = f1_three_reg;
        ctl.frame = f1_frame_reg;
    end

    assign push      = f1_valid_reg && f1_emit_reg;
    assign push_data = {taps[4], taps[3], taps[2], taps[1], taps[0], ctl};

endmodule

/* sv/fogd_back.sv */
// Back end: runs stencil jobs, scales, rounds, saturates and queues results
module fogd_back #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic [fogd_pkg::TAPS*2*SAMPLE_WIDTH+$bits(fogd_pkg::fogd_ctl_t)-1:0] head,
    input  logic [$clog2(fogd_pkg::QUEUE_DEPTH+1)-1:0]   q_count,
    output logic                                         pop,
    input  logic                                         second_order,
    input  logic [fogd_pkg::SCALE_WIDTH-1:0]             step_scale,
    output logic                                         out_valid,
    input  logic                                         out_stall,
    output logic signed [fogd_pkg::OUT_WIDTH-1:0]        deriv_re,
    output logic signed [fogd_pkg::OUT_WIDTH-1:0]        deriv_im,
    output logic                                         run_end,
    output logic                                         frame_end
);

    import fogd_pkg::*;

    localparam int SW    = SAMPLE_WIDTH;
    localparam int PW    = 2*SW;
    localparam int CTLW  = $bits(fogd_ctl_t);
    localparam int SUMW  = SW + 7;
    localparam int MAGW  = SW + 6;
    localparam int PRODW = MAGW + SCALE_WIDTH;
    localparam int RNDW  = PRODW + 1 - FRAC_SHIFT;
    localparam int XW    = (RNDW > 41) ? RNDW : 41;
    localparam int OW    = OUT_WIDTH;
    localparam int OEW   = 2*OW + $bits(fogd_flags_t);
    localparam int OCW   = $clog2(OUT_DEPTH+1);

    fogd_ctl_t               ctl;
    logic signed [SW-1:0]    a_re [TAPS];
    logic signed [SW-1:0]    a_im [TAPS];
    logic signed [SW-1:0]    t_re [TAPS];
    logic signed [SW-1:0]    t_im [TAPS];
    logic                    issue;
    logic                    last_job;
    logic [1:0]              job_reg;

    logic                    v1_reg;
    logic signed [SUMW-1:0]  s_re1_reg;
    logic signed [SUMW-1:0]  s_im1_reg;
    fogd_flags_t             fl1_reg;

    logic                    v2_reg;
    logic [PRODW-1:0]        prod_re2_reg;
    logic [PRODW-1:0]        prod_im2_reg;
    logic                    neg_re2_reg;
    logic                    neg_im2_reg;
    fogd_flags_t             fl2_reg;

    logic [MAGW-1:0]         mag_re;
    logic [MAGW-1:0]         mag_im;
    logic [OEW-1:0]          o_push_data;
    logic [OEW-1:0]          o_head;
    logic [OCW-1:0]          o_count;
    logic                    o_pop;

    function automatic logic signed [SUMW-1:0] stencil(
        input logic                 sec,
        input logic signed [SW-1:0] t0,
        input logic signed [SW-1:0] t1,
        input logic signed [SW-1:0] t2,
        input logic signed [SW-1:0] t3,
        input logic signed [SW-1:0] t4
    );
        logic signed [SUMW-1:0] e0;
        logic signed [SUMW-1:0] e1;
        logic signed [SUMW-1:0] e2;
        logic signed [SUMW-1:0] e3;
        logic signed [SUMW-1:0] e4;
        e0 = SUMW'(t0);
        e1 = SUMW'(t1);
        e2 = SUMW'(t2);
        e3 = SUMW'(t3);
        e4 = SUMW'(t4);
        if (sec)
        begin
            return (e3 <<< 4) + (e1 <<< 4) + (e2 <<< 1) - (e2 <<< 5) - e4 - e0;
        end
        return e0 - e4 + ((e3 - e1) <<< 3);
    endfunction

    function automatic logic [OW-1:0] saturate(
        input logic [PRODW-1:0] p,
        input logic             neg
    );
        logic [PRODW:0] sum;
        logic [XW-1:0]  r;
        sum = {1'b0, p} + (PRODW+1)'(ROUND_HALF);
        r   = XW'(sum >> FRAC_SHIFT);
        if (neg)
        begin
            if (r > XW'(SAT_NEG_MAG))
            begin
                r = XW'(SAT_NEG_MAG);
            end
            return OW'(-r);
        end
        if (r > XW'(SAT_POS))
        begin
            r = XW'(SAT_POS);
        end
        return OW'(r);
    endfunction

    assign ctl = fogd_ctl_t'(head[CTLW-1:0]);

    always_comb
    begin
        for (int i = 0; i < TAPS; i++)
        begin
            a_re[i] = head[CTLW + i*PW + SW +: SW];
            a_im[i] = head[CTLW + i*PW +: SW];
        end
    end

    assign issue    = (q_count != '0) && ((32'(o_count) + 32'(v1_reg) + 32'(v2_reg)) < OUT_DEPTH);
    assign last_job = ctl.three ? (job_reg == 2'd2) : (job_reg == 2'd0);
    assign pop      = issue && last_job;

    // shift the window left by the job index, zero past the right edge
    always_comb
    begin
        logic [2:0] idx;
        idx = '0;
        for (int j = 0; j < TAPS; j++)
        begin
            idx = 3'(job_reg) + 3'(j);
            if (idx < 3'(TAPS))
            begin
                t_re[j] = a_re[idx];
                t_im[j] = a_im[idx];
            end
            else
            begin
                t_re[j] = '0;
                t_im[j] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                job_reg <= last_job ? 2'd0 : job_reg + 2'd1;
            end
            v1_reg <= issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s_re1_reg     <= stencil(second_order, t_re[0], t_re[1], t_re[2], t_re[3], t_re[4]);
            s_im1_reg     <= stencil(second_order, t_im[0], t_im[1], t_im[2], t_im[3], t_im[4]);
            fl1_reg.run   <= last_job;
            fl1_reg.frame <= (job_reg == 2'd2) && ctl.frame;
        end
    end

    assign mag_re = MAGW'(s_re1_reg[SUMW-1] ? -s_re1_reg : s_re1_reg);
    assign mag_im = MAGW'(s_im1_reg[SUMW-1] ? -s_im1_reg : s_im1_reg);

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            prod_re2_reg <= PRODW'(mag_re) * PRODW'(step_scale);
            prod_im2_reg <= PRODW'(mag_im) * PRODW'(step_scale);
            neg_re2_reg  <= s_re1_reg[SUMW-1];
            neg_im2_reg  <= s_im1_reg[SUMW-1];
            fl2_reg      <= fl1_reg;
        end
    end

    assign o_push_data = {saturate(prod_re2_reg, neg_re2_reg),
                          saturate(prod_im2_reg, neg_im2_reg), fl2_reg};

    fogd_fifo #(
        .WIDTH(OEW),
        .DEPTH(OUT_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (v2_reg),
        .push_data (o_push_data),
        .pop       (o_pop),
        .head      (o_head),
        .count     (o_count)
    );

    assign out_valid = o_count != '0;
    assign o_pop     = out_valid && !out_stall;
    assign deriv_re  = o_head[OEW-1 -: OW];
    assign deriv_im  = o_head[OEW-1-OW -: OW];
    assign run_end   = o_head[1];
    assign frame_end = o_head[0];

endmodule

/* sv/fogd_checker.sv */
// Port-level checks of the fourth-order grid derivative unit and their binding
module fogd_port_checks (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  out_valid,
    input logic                                  out_stall,
    input logic signed [fogd_pkg::OUT_WIDTH-1:0] deriv_re,
    input logic signed [fogd_pkg::OUT_WIDTH-1:0] deriv_im,
    input logic                                  run_end,
    input logic                                  frame_end
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(deriv_re) && $stable(deriv_im)
            && $stable(run_end) && $stable(frame_end))
        else $error("stalled result changed");

    a_frame_is_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> run_end)
        else $error("frame end without run end");

    a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !out_valid)
        else $error("result present right after reset");

    a_single_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && frame_end |=> !(out_valid && frame_end))
        else $error("back-to-back frame end transfers");

endmodule

bind fourth_order_grid_derivative_unit fogd_port_checks u_fogd_port_checks (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .deriv_re  (deriv_re),
    .deriv_im  (deriv_im),
    .run_end   (run_end),
    .frame_end (frame_end)
);

/* verif/fogd_checker.sv */
// Checker that predicts and compares the derivative results of the grid derivative unit
`timescale 1ns / 1ps

module fogd_checker #(
    parameter int MAX_LEN = 1024,
    parameter int MAX_CNT = 1024
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic                                   in_stall,
    input  logic signed [23:0]                     sample_re,
    input  logic signed [23:0]                     sample_im,
    input  logic                                   out_valid,
    input  logic                                   out_stall,
    input  logic signed [fogd_pkg::OUT_WIDTH-1:0]  deriv_re,
    input  logic signed [fogd_pkg::OUT_WIDTH-1:0]  deriv_im,
    input  logic                                   run_end,
    input  logic                                   frame_end,
    input  logic                                   cfg_write,
    input  logic [fogd_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [fogd_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
    output int                                     fail_count,
    output int                                     pending
);
    import fogd_pkg::*;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] re;
        logic signed [OUT_WIDTH-1:0] im;
        logic                        run;
        logic                        frame;
    } deriv_point_t;

    deriv_point_t expected_points[$];

    logic        second_order;
    logic        along_columns;
    logic [10:0] row_length;
    logic [10:0] row_count;
    logic [31:0] step_scale;

    longint window_re[4];
    longint window_im[4];
    longint store_re[4*MAX_LEN];
    longint store_im[4*MAX_LEN];
    int     col_pos;
    int     row_pos;

    function automatic logic [OUT_WIDTH-1:0] scale_saturate(longint s);
        logic            neg;
        longint unsigned mag;
        longint unsigned res;
        neg = s < 0;
        mag = neg ? longint'(-s) : longint'(s);
        res = mag * longint'(step_scale >> 16)
            + ((mag * longint'(step_scale & 32'hFFFF) + 32768) >> 16);
        if (neg)
        begin
            if (res > 64'h80_0000_0000)
                res = 64'h80_0000_0000;
            return OUT_WIDTH'(-res);
        end
        if (res > 64'h7F_FFFF_FFFF)
            res = 64'h7F_FFFF_FFFF;
        return OUT_WIDTH'(res);
    endfunction

    function automatic longint stencil_sum(longint t0, longint t1, longint t2,
                                           longint t3, longint t4);
        if (second_order)
            return -t4 + 16 * t3 - 30 * t2 + 16 * t1 - t0;
        return t0 - t4 + 8 * (t3 - t1);
    endfunction

    function automatic void restart_frame();
        col_pos = 0;
        row_pos = 0;
        for (int i = 0; i < 4; i++)
        begin
            window_re[i] = 0;
            window_im[i] = 0;
        end
    endfunction

    function automatic void predict_sample(logic signed [23:0] sr, logic signed [23:0] si);
        int           len;
        int           cnt;
        int           c;
        int           r;
        bit           last_col;
        bit           last_row;
        int           first;
        int           lastk;
        longint       ar[7];
        longint       ai[7];
        deriv_point_t pt;
        len = row_length < 4 ? 4 : (row_length > MAX_LEN ? MAX_LEN : row_length);
        cnt = row_count < 4 ? 4 : (row_count > MAX_CNT ? MAX_CNT : row_count);
        c = col_pos % len;
        r = row_pos % cnt;
        last_col = (c == len - 1);
        last_row = (r == cnt - 1);
        for (int i = 0; i < 7; i++)
        begin
            ar[i] = 0;
            ai[i] = 0;
        end
        if (along_columns)
        begin
            for (int k = 1; k <= 4; k++)
            begin
                if (r >= k)
                begin
                    ar[4-k] = store_re[((r - k) & 3) * MAX_LEN + c];
                    ai[4-k] = store_im[((r - k) & 3) * MAX_LEN + c];
                end
            end
            store_re[(r & 3) * MAX_LEN + c] = sr;
            store_im[(r & 3) * MAX_LEN + c] = si;
            first = (r >= 2) ? 2 : 5;
            lastk = last_row ? 4 : 2;
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                ar[i] = window_re[3-i];
                ai[i] = window_im[3-i];
            end
            for (int i = 3; i > 0; i--)
            begin
                window_re[i] = window_re[i-1];
                window_im[i] = window_im[i-1];
            end
            window_re[0] = sr;
            window_im[0] = si;
            first = (c >= 2) ? 2 : 5;
            lastk = last_col ? 4 : 2;
        end
        ar[4] = sr;
        ai[4] = si;
        for (int k = first; k <= lastk; k++)
        begin
            pt.re = scale_saturate(stencil_sum(ar[k-2], ar[k-1], ar[k], ar[k+1], ar[k+2]));
            pt.im = scale_saturate(stencil_sum(ai[k-2], ai[k-1], ai[k], ai[k+1], ai[k+2]));
            pt.run = (k == lastk);
            pt.frame = (k == 4) && last_col && last_row;
            expected_points.push_back(pt);
        end
        if (last_col)
        begin
            col_pos = 0;
            for (int i = 0; i < 4; i++)
            begin
                window_re[i] = 0;
                window_im[i] = 0;
            end
            row_pos = last_row ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
            row_pos = r;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        deriv_point_t pt;
        if (!rst_n)
        begin
            expected_points.delete();
            fail_count <= 0;
            pending <= 0;
            second_order = 1'b0;
            along_columns = 1'b0;
            row_length = LEN_RESET;
            row_count = LEN_RESET;
            step_scale = SCALE_RESET;
            restart_frame();
            for (int i = 0; i < 4 * MAX_LEN; i++)
            begin
                store_re[i] = 0;
                store_im[i] = 0;
            end
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_points.size() == 0)
                begin
                    $error("unexpected derivative transfer: re %0d im %0d", deriv_re, deriv_im);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    pt = expected_points.pop_front();
                    if (pt.re !== deriv_re || pt.im !== deriv_im || pt.run !== run_end
                        || pt.frame !== frame_end)
                    begin
                        fail_count <= fail_count + 1;
                        if (pt.re !== deriv_re)
                            $error("deriv_re expected %0d actual %0d", pt.re, deriv_re);
                        if (pt.im !== deriv_im)
                            $error("deriv_im expected %0d actual %0d", pt.im, deriv_im);
                        if (pt.run !== run_end)
                            $error("run_end expected %0d actual %0d", pt.run, run_end);
                        if (pt.frame !== frame_end)
                            $error("frame_end expected %0d actual %0d", pt.frame, frame_end);
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_sample(sample_re, sample_im);
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SECOND_ORDER:  second_order = cfg_data[0];
                    REG_ALONG_COLUMNS:
                    begin
                        along_columns = cfg_data[0];
                        restart_frame();
                    end
                    REG_ROW_LENGTH:
                    begin
                        row_length = cfg_data[10:0];
                        restart_frame();
                    end
                    REG_ROW_COUNT:
                    begin
                        row_count = cfg_data[10:0];
                        restart_frame();
                    end
                    REG_STEP_SCALE:    step_scale = cfg_data;
                    default: ;
                endcase
            end
            pending <= expected_points.size();
        end
    end

endmodule

/* verif/fourth_order_grid_derivative_unit_test.sv */
// Stimulus and verdict for the fourth-order grid derivative unit
`timescale 1ns / 1ps

module fourth_order_grid_derivative_unit_test;
    import fogd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic signed [23:0]           sample_re;
    logic signed [23:0]           sample_im;
    logic                         out_valid;
    logic                         out_stall;
    logic signed [OUT_WIDTH-1:0]  deriv_re;
    logic signed [OUT_WIDTH-1:0]  deriv_im;
    logic                         run_end;
    logic                         frame_end;
    logic                         cfg_write;
    logic [CFG_INDEX_WIDTH-1:0]   cfg_index;
    logic [CFG_DATA_WIDTH-1:0]    cfg_data;
    int                           fail_count;
    int                           pending;
    int                           sender_idle_pct;
    int                           stall_pct;
    logic                         hold_start;
    int                           hold_left;
    int                           cycle_count;

    fourth_order_grid_derivative_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .sample_re(sample_re), .sample_im(sample_im),
        .out_valid(out_valid), .out_stall(out_stall),
        .deriv_re(deriv_re), .deriv_im(deriv_im),
        .run_end(run_end), .frame_end(frame_end),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    fogd_checker checker_inst (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .sample_re(sample_re), .sample_im(sample_im),
        .out_valid(out_valid), .out_stall(out_stall),
        .deriv_re(deriv_re), .deriv_im(deriv_im),
        .run_end(run_end), .frame_end(frame_end),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_start)
        begin
            hold_left <= 300;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(fogd_reg_t idx, logic [31:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic configure(logic so, logic ac, logic [10:0] len, logic [10:0] cnt,
                             logic [31:0] scale);
        write_reg(REG_SECOND_ORDER, {31'd0, so});
        write_reg(REG_ALONG_COLUMNS, {31'd0, ac});
        write_reg(REG_ROW_LENGTH, {21'd0, len});
        write_reg(REG_ROW_COUNT, {21'd0, cnt});
        write_reg(REG_STEP_SCALE, scale);
        cfg_write <= 1'b0;
    endtask

    task automatic send_sample(logic signed [23:0] re, logic signed [23:0] im);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample_re <= re;
        sample_im <= im;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic signed [23:0] random_sample();
        case ($urandom_range(5))
            0: return 24'sh7FFFFF;
            1: return -24'sh800000;
            2: return 24'($signed($urandom_range(15)) - 8);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic random_phase(int n, int mode);
        case (mode)
            0:
            begin
                sender_idle_pct = 0;
                stall_pct = 0;
            end
            1:
            begin
                sender_idle_pct = 56;
                stall_pct = 0;
            end
            2:
            begin
                sender_idle_pct = 0;
                stall_pct = 56;
            end
            default:
            begin
                sender_idle_pct = 18;
                stall_pct = 18;
            end
        endcase
        for (int i = 0; i < n; i++)
            send_sample(random_sample(), random_sample());
        drain();
    endtask

    initial
    begin
        logic signed [23:0] edge_vals[5];
        edge_vals = '{24'sh7FFFFF, -24'sh800000, 24'sd0, 24'sd1, -24'sd1};
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample_re = '0;
        sample_im = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_start = 1'b0;
        sender_idle_pct = 0;
        stall_pct = 0;
        cycle_count = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        configure(1'b0, 1'b0, 11'd4, 11'd4, 32'h0001_0000);
        for (int i = 0; i < 20; i++)
            send_sample(edge_vals[i % 5], edge_vals[(i * 3 + 1) % 5]);
        drain();

        configure(1'b1, 1'b0, 11'd5, 11'd4, 32'hFFFF_FFFF);
        random_phase(30, 1);
        configure(1'b0, 1'b1, 11'd4, 11'd4, 32'h0001_8000);
        random_phase(32, 2);

        configure(1'b1, 1'b1, 11'd6, 11'd5, $urandom);
        sender_idle_pct = 0;
        stall_pct = 0;
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        for (int i = 0; i < 24; i++)
            send_sample(random_sample(), random_sample());
        drain();
        for (int i = 0; i < 16; i++)
            send_sample(random_sample(), random_sample());
        drain();

        configure(1'b0, 1'b0, 11'd3, 11'd0, 32'h0000_4000);
        random_phase(16, 3);
        configure(1'b1, 1'b0, 11'd2047, 11'd2047, 32'h0000_0000);
        random_phase(12, 0);
        configure(1'b1, 1'b1, 11'd7, 11'd2047, $urandom);
        random_phase(20, 3);
        configure(1'b0, 1'b1, 11'd4, 11'd4, $urandom);
        random_phase(12, 2);

        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
